[rtl/pphl_pkg.sv]
`default_nettype none

package pphl_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int CFG_W    = 5;
  localparam int EIDX_W   = 4;
  localparam int ADDR_W   = 32;
  localparam int PLEN_W   = 6;
  localparam int PORT_W   = 16;
  localparam int HINT_W   = 32;

  // Common width for comparing the count and slot fields against the depth
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Returned hint word when no entry matches
  localparam logic [HINT_W-1:0] HINT_MISS = 32'hFFFF_FFFF;

  // Transaction kinds
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

  // One stored table entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PLEN_W-1:0] prefix;
    logic [PORT_W-1:0] port;
    logic [HINT_W-1:0] hints;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Lookup key held during a scan
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } key_t;

endpackage

`default_nettype wire

[rtl/pphl_ram.sv]
`default_nettype none

module pphl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/pphl_match.sv]
`default_nettype none

module pphl_match (
  input  wire pphl_pkg::entry_t entry,
  input  wire pphl_pkg::key_t   key,
  output logic                  match
);

  logic [pphl_pkg::ADDR_W-1:0] mask;

  // Leading-ones mask; zero prefix gives no bits, 32 and above gives all bits
  assign mask = ~({pphl_pkg::ADDR_W{1'b1}} >> entry.prefix);

  // Compare masked address and port
  assign match = ((entry.addr & mask) == (key.addr & mask)) && (entry.port == key.port);

endmodule

`default_nettype wire

[rtl/prefix_port_hint_lookup_unit.sv]
// Lookup: from acceptance to result register, the unit reads entries from slot 0 up
//   to and including the first match (all count entries when none matches, so an
//   empty table skips the scan).
// Throughput: one lookup at a time, as no new transaction is accepted until the
//   result moves to the output register; the scan reads one entry per cycle through
//   the single read port of the entry RAM, and a write completes while idle.
// Reset: synchronous active-low; clears control state and the entry count to 0.
//   Table contents are not cleared and are undefined until written.
`default_nettype none

module prefix_port_hint_lookup_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Configuration
  input  wire logic                          cfg_write_en,
  input  wire logic [pphl_pkg::CFG_W-1:0]    cfg_write_data,
  // Input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_kind,
  input  wire logic [pphl_pkg::EIDX_W-1:0]   in_entry_index,
  input  wire logic [pphl_pkg::ADDR_W-1:0]   in_ip_address,
  input  wire logic [pphl_pkg::PLEN_W-1:0]   in_prefix_length,
  input  wire logic [pphl_pkg::PORT_W-1:0]   in_port_number,
  input  wire logic [pphl_pkg::HINT_W-1:0]   in_hint_word,
  // Result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic      [pphl_pkg::HINT_W-1:0]   out_hints_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [pphl_pkg::CFG_W-1:0]   active_r;
  logic [pphl_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [pphl_pkg::CNT_W-1:0]   count_clamp;
  logic [pphl_pkg::IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  pphl_pkg::key_t               key_r, key_nxt;
  logic                         res_hit_r, res_hit_nxt;
  logic [pphl_pkg::HINT_W-1:0]  res_hints_r, res_hints_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r, out_hit_nxt;
  logic [pphl_pkg::HINT_W-1:0]  out_hints_r, out_hints_nxt;

  logic                         in_fire;
  logic                         out_free;
  logic                         last_entry;
  logic                         wr_en;
  logic                         slot_ok;
  logic [pphl_pkg::IDX_W-1:0]   wr_addr;
  logic [pphl_pkg::IDX_W-1:0]   rd_addr;
  pphl_pkg::entry_t             wr_entry;
  pphl_pkg::entry_t             rd_entry;
  logic                         entry_match;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Clamp the configured count to the table depth
  assign count_clamp =
    (pphl_pkg::CMP_W'(active_r) > pphl_pkg::CMP_W'(pphl_pkg::TABLE_DEPTH))
      ? pphl_pkg::CNT_W'(pphl_pkg::TABLE_DEPTH) : pphl_pkg::CNT_W'(active_r);

  // Write path: drop writes to slots beyond the table
  assign slot_ok  = pphl_pkg::CMP_W'(in_entry_index) < pphl_pkg::CMP_W'(pphl_pkg::TABLE_DEPTH);
  assign wr_en    = in_fire && (in_kind == pphl_pkg::KIND_WRITE) && slot_ok;
  assign wr_addr  = pphl_pkg::IDX_W'(in_entry_index);
  assign wr_entry = '{addr: in_ip_address, prefix: in_prefix_length,
                      port: in_port_number, hints: in_hint_word};

  // Read address: slot 0 on lookup acceptance, then the slot after the pending one
  assign rd_addr = (state_r == ST_SCAN) ? (pend_idx_r + 1'b1) : '0;

  assign last_entry = (pphl_pkg::CNT_W'(pend_idx_r) + 1'b1) == count_r;

  pphl_ram #(
    .WIDTH (pphl_pkg::ENTRY_W),
    .DEPTH (pphl_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  pphl_match u_match (
    .entry (rd_entry),
    .key   (key_r),
    .match (entry_match)
  );

  // Sequencer: accept, scan one entry per cycle, hold result until output frees
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pend_idx_nxt  = pend_idx_r;
    key_nxt       = key_r;
    res_hit_nxt   = res_hit_r;
    res_hints_nxt = res_hints_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_hints_nxt = out_hints_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_kind == pphl_pkg::KIND_LOOKUP)) begin
          key_nxt       = '{addr: in_ip_address, port: in_port_number};
          count_nxt     = count_clamp;
          pend_idx_nxt  = '0;
          res_hit_nxt   = 1'b0;
          res_hints_nxt = pphl_pkg::HINT_MISS;
          state_nxt     = (count_clamp == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (entry_match) begin
          res_hit_nxt   = 1'b1;
          res_hints_nxt = rd_entry.hints;
          state_nxt     = ST_DONE;
        end else if (last_entry) begin
          state_nxt     = ST_DONE;
        end else begin
          pend_idx_nxt  = pend_idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_hints_nxt = res_hints_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        active_r <= cfg_write_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    count_r     <= count_nxt;
    pend_idx_r  <= pend_idx_nxt;
    key_r       <= key_nxt;
    res_hit_r   <= res_hit_nxt;
    res_hints_r <= res_hints_nxt;
    out_hit_r   <= out_hit_nxt;
    out_hints_r <= out_hints_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_hints_out = out_hints_r;

  // Scan never runs past the active count
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (pphl_pkg::CNT_W'(pend_idx_r) < count_r))
    else $error("scan index beyond active count");

  // A miss result carries the all-ones hint word
  a_miss_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hints_out == pphl_pkg::HINT_MISS))
    else $error("miss result without all-ones hint word");

  // A lookup with an empty table goes straight to the result stage
  a_empty_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_kind == pphl_pkg::KIND_LOOKUP) && (count_clamp == '0))
      |=> (state_r == ST_DONE))
    else $error("empty-table lookup did not skip the scan");

  // A finished result moves into a free output register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_free) |=> (out_valid && (state_r == ST_IDLE)))
    else $error("finished result not loaded into output register");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF_NS   = 4;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 24;
  localparam int TIMEOUT_NS    = 4_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 270;

  // One input transaction as the sender sees it
  typedef struct {
    logic                        kind;
    logic [pphl_pkg::EIDX_W-1:0] slot;
    logic [pphl_pkg::ADDR_W-1:0] addr;
    logic [pphl_pkg::PLEN_W-1:0] plen;
    logic [pphl_pkg::PORT_W-1:0] port;
    logic [pphl_pkg::HINT_W-1:0] hint;
  } table_req_t;

  // Result of one lookup
  typedef struct packed {
    logic                        hit;
    logic [pphl_pkg::HINT_W-1:0] hints;
  } lookup_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_write_en;
  logic [pphl_pkg::CFG_W-1:0]  cfg_write_data;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_kind;
  logic [pphl_pkg::EIDX_W-1:0] in_entry_index;
  logic [pphl_pkg::ADDR_W-1:0] in_ip_address;
  logic [pphl_pkg::PLEN_W-1:0] in_prefix_length;
  logic [pphl_pkg::PORT_W-1:0] in_port_number;
  logic [pphl_pkg::HINT_W-1:0] in_hint_word;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_hit;
  logic [pphl_pkg::HINT_W-1:0] out_hints_out;

  // Shadow copy of the classifier table and its entry count
  logic [pphl_pkg::ADDR_W-1:0] tbl_addr  [pphl_pkg::TABLE_DEPTH];
  logic [pphl_pkg::PLEN_W-1:0] tbl_plen  [pphl_pkg::TABLE_DEPTH];
  logic [pphl_pkg::PORT_W-1:0] tbl_port  [pphl_pkg::TABLE_DEPTH];
  logic [pphl_pkg::HINT_W-1:0] tbl_hints [pphl_pkg::TABLE_DEPTH];
  logic [pphl_pkg::CFG_W-1:0]  active_cnt;

  lookup_result_t pending_lookups [$];
  int err_count = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req_len   = 0;
  int hold_req_seq   = 0;

  prefix_port_hint_lookup_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_entry_index   (in_entry_index),
    .in_ip_address    (in_ip_address),
    .in_prefix_length (in_prefix_length),
    .in_port_number   (in_port_number),
    .in_hint_word     (in_hint_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_hints_out    (out_hints_out)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Address bits compared for a stored prefix; zero compares nothing, above 32 compares all
  function automatic logic [pphl_pkg::ADDR_W-1:0] net_mask(
      input logic [pphl_pkg::PLEN_W-1:0] plen);
    int unsigned p;
    p = (plen > pphl_pkg::ADDR_W) ? pphl_pkg::ADDR_W : plen;
    if (p == 0) return '0;
    return {pphl_pkg::ADDR_W{1'b1}} << (pphl_pkg::ADDR_W - p);
  endfunction

  // First matching entry among the active ones wins
  function automatic lookup_result_t classify_key(input logic [pphl_pkg::ADDR_W-1:0] addr,
                                                  input logic [pphl_pkg::PORT_W-1:0] port);
    lookup_result_t res;
    int unsigned    scanned;
    logic [pphl_pkg::ADDR_W-1:0] m;
    res.hit   = 1'b0;
    res.hints = pphl_pkg::HINT_MISS;
    scanned   = (active_cnt > pphl_pkg::TABLE_DEPTH) ? pphl_pkg::TABLE_DEPTH : active_cnt;
    for (int i = 0; i < scanned; i++) begin
      m = net_mask(tbl_plen[i]);
      if (!res.hit && ((tbl_addr[i] ^ addr) & m) == '0 && tbl_port[i] == port) begin
        res.hit   = 1'b1;
        res.hints = tbl_hints[i];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Offer one transaction, hold it until accepted, then update the shadow table
  task automatic send_item(input table_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_kind          = req.kind;
    in_entry_index   = req.slot;
    in_ip_address    = req.addr;
    in_prefix_length = req.plen;
    in_port_number   = req.port;
    in_hint_word     = req.hint;
    in_valid         = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req.kind == pphl_pkg::KIND_WRITE) begin
      tbl_addr[req.slot]  = req.addr;
      tbl_plen[req.slot]  = req.plen;
      tbl_port[req.slot]  = req.port;
      tbl_hints[req.slot] = req.hint;
    end else begin
      pending_lookups.push_back(classify_key(req.addr, req.port));
    end
    @(negedge clk);
  endtask

  function automatic table_req_t random_req();
    table_req_t req;
    req.kind = pphl_pkg::KIND_LOOKUP;
    req.slot = pphl_pkg::EIDX_W'($urandom_range(pphl_pkg::TABLE_DEPTH - 1));
    req.addr = pphl_pkg::ADDR_W'($urandom());
    req.plen = pphl_pkg::PLEN_W'($urandom_range(63));
    req.port = pphl_pkg::PORT_W'($urandom());
    req.hint = pphl_pkg::HINT_W'($urandom());
    return req;
  endfunction

  task automatic write_entry(input int slot, input logic [pphl_pkg::ADDR_W-1:0] addr,
                             input int plen, input int port,
                             input logic [pphl_pkg::HINT_W-1:0] hint);
    table_req_t req;
    req      = random_req();
    req.kind = pphl_pkg::KIND_WRITE;
    req.slot = pphl_pkg::EIDX_W'(slot);
    req.addr = addr;
    req.plen = pphl_pkg::PLEN_W'(plen);
    req.port = pphl_pkg::PORT_W'(port);
    req.hint = hint;
    send_item(req);
  endtask

  // Unused fields of a lookup get random values
  task automatic lookup_key(input logic [pphl_pkg::ADDR_W-1:0] addr, input int port);
    table_req_t req;
    req      = random_req();
    req.addr = addr;
    req.port = pphl_pkg::PORT_W'(port);
    send_item(req);
  endtask

  // Drain all results and let a trailing write retire
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_active_count(input logic [pphl_pkg::CFG_W-1:0] count);
    wait_idle();
    cfg_write_en   = 1'b1;
    cfg_write_data = count;
    @(negedge clk);
    cfg_write_en   = 1'b0;
    active_cnt     = count;
  endtask

  // Mix of writes and lookups, most lookups aimed at a live entry
  task automatic send_random_items(input int n_items);
    table_req_t req;
    int unsigned scanned;
    int unsigned s;
    int unsigned pick;
    logic [pphl_pkg::ADDR_W-1:0] m;
    repeat (n_items) begin
      scanned = (active_cnt > pphl_pkg::TABLE_DEPTH) ? pphl_pkg::TABLE_DEPTH : active_cnt;
      req     = random_req();
      if ($urandom_range(99) < 25) begin
        req.kind = pphl_pkg::KIND_WRITE;
        pick     = $urandom_range(9);
        if (pick == 0)
          req.plen = '0;
        else if (pick == 1)
          req.plen = pphl_pkg::PLEN_W'($urandom_range(63, pphl_pkg::ADDR_W + 1));
        else
          req.plen = pphl_pkg::PLEN_W'($urandom_range(pphl_pkg::ADDR_W, 1));
        // Share addresses and ports with stored entries so priority gets exercised
        if ($urandom_range(99) < 30)
          req.addr = tbl_addr[$urandom_range(pphl_pkg::TABLE_DEPTH - 1)]
                     ^ pphl_pkg::ADDR_W'($urandom_range(255));
        if ($urandom_range(99) < 40)
          req.port = tbl_port[$urandom_range(pphl_pkg::TABLE_DEPTH - 1)];
      end else if (scanned > 0 && $urandom_range(99) < 60) begin
        s        = $urandom_range(scanned - 1);
        m        = net_mask(tbl_plen[s]);
        req.addr = (tbl_addr[s] & m) | (pphl_pkg::ADDR_W'($urandom()) & ~m);
        req.port = tbl_port[s];
      end else if ($urandom_range(1) == 1) begin
        req.port = tbl_port[$urandom_range(pphl_pkg::TABLE_DEPTH - 1)];
      end
      send_item(req);
    end
  endtask

  // An empty count never matches
  task automatic test_empty_table();
    set_active_count('0);
    lookup_key(32'hC0A8_0105, 443);
  endtask

  // Fill every slot, then look up keys aimed at the special entries with the whole table active
  task automatic test_directed_entries();
    write_entry(0, 32'hC0A8_0000, 16, 443, 32'h1234_5678);
    write_entry(1, 32'hC0A8_0100, 24, 443, 32'hFFFF_FFFF);
    write_entry(2, 32'hFFFF_FFFF, 32, 16'hFFFF, 32'h0000_0000);
    write_entry(3, 32'h0000_0000, 32, 0, 32'hA5A5_A5A5);
    write_entry(4, 32'h0A00_0001, 63, 80, 32'h5A5A_5A5A);
    write_entry(5, 32'hDEAD_BEEF, 0, 8080, 32'h0123_4567);
    for (int i = 6; i < pphl_pkg::TABLE_DEPTH - 1; i++)
      write_entry(i, pphl_pkg::ADDR_W'($urandom()), 32, 1000 + i,
                  pphl_pkg::HINT_W'($urandom()));
    write_entry(pphl_pkg::TABLE_DEPTH - 1, 32'h7F00_0001, 1, 22, 32'h89AB_CDEF);

    set_active_count(pphl_pkg::CFG_W'(pphl_pkg::TABLE_DEPTH));
    lookup_key(32'hC0A8_0105, 443);
    lookup_key(32'hFFFF_FFFF, 16'hFFFF);
    lookup_key(32'h0000_0000, 0);
    lookup_key(32'h0A00_0001, 80);
    lookup_key(32'h0A00_0000, 80);
    lookup_key(32'h0102_0304, 8080);
    lookup_key(32'h7FFF_FFFF, 22);
  endtask

  // Count of one, and counts beyond the table depth
  task automatic test_count_extremes();
    set_active_count(pphl_pkg::CFG_W'(1));
    lookup_key(32'hFFFF_FFFF, 16'hFFFF);
    set_active_count(pphl_pkg::CFG_W'(pphl_pkg::TABLE_DEPTH + 1));
    lookup_key(32'h7FFF_FFFF, 22);
    set_active_count({pphl_pkg::CFG_W{1'b1}});
    lookup_key(32'h7FFF_FFFF, 22);
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                     input logic [pphl_pkg::CFG_W-1:0] count);
    set_active_count(count);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    send_random_items(PHASE_ITEMS);
  endtask

  // Hold the result side off while lookups keep coming, so the input stalls
  task automatic test_output_backpressure();
    set_active_count(pphl_pkg::CFG_W'(pphl_pkg::TABLE_DEPTH));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_len   = HOLD_CYCLES;
    hold_req_seq++;
    send_random_items(40);
  endtask

  // Result side: random stalls plus a long hold on request
  always @(negedge clk) begin
    int hold_left;
    int hold_seen;
    if (hold_req_seq != hold_seen) begin
      hold_seen = hold_req_seq;
      hold_left = hold_req_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transaction with the oldest pending lookup
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("result with no lookup pending: hit %0b hints %h",
                                  out_hit, out_hints_out));
      end else begin
        want = pending_lookups.pop_front();
        if (out_hit !== want.hit)
          report_mismatch($sformatf("hit %0b, expected %0b", out_hit, want.hit));
        if (out_hints_out !== want.hints)
          report_mismatch($sformatf("hints %h, expected %h", out_hints_out, want.hints));
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_write_en     = 1'b0;
    cfg_write_data   = '0;
    in_valid         = 1'b0;
    in_kind          = pphl_pkg::KIND_LOOKUP;
    in_entry_index   = '0;
    in_ip_address    = '0;
    in_prefix_length = '0;
    in_port_number   = '0;
    in_hint_word     = '0;
    active_cnt       = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_directed_entries();
    test_count_extremes();
    test_random_traffic(0, 0, pphl_pkg::CFG_W'(pphl_pkg::TABLE_DEPTH));
    test_random_traffic(50, 0,
                        pphl_pkg::CFG_W'($urandom_range(pphl_pkg::TABLE_DEPTH - 1, 1)));
    test_random_traffic(0, 50, {pphl_pkg::CFG_W{1'b1}});
    test_random_traffic(22, 22,
                        pphl_pkg::CFG_W'($urandom_range(30, pphl_pkg::TABLE_DEPTH + 1)));
    test_output_backpressure();
    wait_idle();

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
